// File: hw/rtl/wch_pkg.sv
// shared types and constants, including the fnv offset basis, for the word count hash table
`default_nettype none
package wch_pkg;
	localparam int unsigned TABLE_SLOTS = 1024;
	localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);
	localparam int unsigned MAX_WORD_LEN = 32;
	localparam int unsigned LEN_W = 6;
	localparam int unsigned BIDX_W = $clog2(MAX_WORD_LEN);
	localparam int unsigned CHUNKS = (MAX_WORD_LEN + 7) / 8;
	localparam int unsigned CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int unsigned WADDR_W = SLOT_W + CHUNK_W;

	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

	localparam logic OP_FEED = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_LONG = 2'd2;

	typedef struct packed {
		logic        op;
		logic [7:0]  data_byte;
		logic        end_of_data;
		logic [9:0]  slot_index;
	} in_t;

	typedef struct packed {
		logic [9:0]  slot;
		logic [31:0] count;
		logic [5:0]  wlen;
		logic [63:0] word_hash;
		logic        is_new;
		logic [1:0]  status;
		logic [63:0] word_chunk;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot_addr;
		logic               cnt_we;
		logic [31:0]        cnt_wdata;
		logic               len_we;
		logic [LEN_W-1:0]   len_wdata;
		logic [WADDR_W-1:0] word_addr;
		logic               word_we;
		logic [63:0]        word_wdata;
	} tbl_req_t;

	typedef struct packed {
		logic [31:0]      cnt;
		logic [LEN_W-1:0] len;
		logic [63:0]      word;
	} tbl_rsp_t;
endpackage
`default_nettype wire

// File: hw/rtl/wch_hash.sv
// fnv-1a 64-bit byte step: xor then multiply by the prime as shifts and adds
`default_nettype none
module wch_hash import wch_pkg::*; (
	input  wire logic [63:0] hash,
	input  wire logic [7:0]  data_byte,
	output logic [63:0]      hash_next
);
	logic [63:0] x;

	// prime is 2^40 + 0x1b3
	always_comb begin
		x = hash ^ {56'd0, data_byte};
		hash_next = x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
	end
endmodule
`default_nettype wire

// File: hw/rtl/wch_table.sv
// slot count, length and word chunk memories with registered reads
`default_nettype none
module wch_table import wch_pkg::*; (
	input  wire logic     clk,
	input  wire tbl_req_t req,
	output tbl_rsp_t      rsp
);
	logic [31:0]      cnt_mem  [TABLE_SLOTS];
	logic [LEN_W-1:0] len_mem  [TABLE_SLOTS];
	logic [63:0]      word_mem [TABLE_SLOTS * CHUNKS];

	always_ff @(posedge clk) begin
		if (req.cnt_we) begin
			cnt_mem[req.slot_addr] <= req.cnt_wdata;
		end
		rsp.cnt <= cnt_mem[req.slot_addr];
	end

	always_ff @(posedge clk) begin
		if (req.len_we) begin
			len_mem[req.slot_addr] <= req.len_wdata;
		end
		rsp.len <= len_mem[req.slot_addr];
	end

	always_ff @(posedge clk) begin
		if (req.word_we) begin
			word_mem[req.word_addr] <= req.word_wdata;
		end
		rsp.word <= word_mem[req.word_addr];
	end
endmodule
`default_nettype wire

// File: hw/rtl/word_count_hash_table_core.sv
// top level: byte intake, fnv hashing and the probe / read sequencer
`default_nettype none
// Word count hash table. Feed requests (op 0) carry one text byte; runs of
// ASCII letters and digits form words, hashed with 64-bit FNV-1a and counted
// in a 1024-slot open-addressed table with linear probing. A byte that
// does not close a word is taken while the sequencer stays idle. Closing a
// word runs the probe sequencer: each probed slot has its 8-byte chunks read
// and then compared in turn in the single 64-bit comparator; an insert
// writes the chunks one at a time through the single write port of the
// word memory. A read request (op 1) returns 1 to 4 results, each passing
// through the read, data and emit states. After reset the block runs a
// clearing pass over the count memory, one slot per cycle, and holds stall
// high until it ends. Results wait in an output register, so feed bytes keep
// flowing while a result is not yet taken, until the next word closes.
module word_count_hash_table_core import wch_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_stall,
	output out_t      out_data
);
	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_PRD  = 4'd2;
	localparam logic [3:0] S_PCMP = 4'd3;
	localparam logic [3:0] S_INS  = 4'd4;
	localparam logic [3:0] S_RRD  = 4'd5;
	localparam logic [3:0] S_RDAT = 4'd6;
	localparam logic [3:0] S_EMIT = 4'd7;

	localparam logic [CHUNK_W-1:0] K_LAST = CHUNK_W'(CHUNKS - 1);

	logic [3:0]          state_q;
	logic [SLOT_W-1:0]   clr_q;
	logic                in_word_q;
	logic                overlong_q;
	logic [LEN_W-1:0]    len_q;
	logic [63:0]         hash_q;
	logic [63:0]         chunk_q [CHUNKS];
	logic [SLOT_W-1:0]   idx_q;
	logic [SLOT_W:0]     probes_q;
	logic [CHUNK_W-1:0]  k_q;
	logic [CHUNK_W:0]    n_q;
	logic [31:0]         cnt_q;
	logic                rd_mode_q;
	out_t                res_q;
	out_t                out_q;
	logic                out_valid_q;

	tbl_req_t            req;
	tbl_rsp_t            rsp;

	// byte intake
	logic                is_word_byte;
	logic [63:0]         hash_in;
	logic [63:0]         hash_next;
	logic [LEN_W-1:0]    len_in;
	logic [63:0]         chunk_next [CHUNKS];
	logic                accept;
	logic                out_free;

	// compare unit and saturating count
	logic                chunk_eq;
	logic [31:0]         cnt_use;
	logic [31:0]         cnt_sat;
	logic [LEN_W-1:0]    rd_len;
	logic [CHUNK_W:0]    rd_n;

	wch_hash u_hash (
		.hash      (hash_in),
		.data_byte (in_data.data_byte),
		.hash_next (hash_next)
	);

	wch_table u_table (
		.clk (clk),
		.req (req),
		.rsp (rsp)
	);

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		is_word_byte = (in_data.data_byte >= 8'h30 && in_data.data_byte <= 8'h39)
			|| (in_data.data_byte >= 8'h41 && in_data.data_byte <= 8'h5a)
			|| (in_data.data_byte >= 8'h61 && in_data.data_byte <= 8'h7a);
		hash_in = in_word_q ? hash_q : FNV_BASIS;
		len_in  = in_word_q ? len_q : '0;
		// a new word starts from an all-zero buffer
		for (int c = 0; c < CHUNKS; c++) begin
			chunk_next[c] = in_word_q ? chunk_q[c] : 64'd0;
		end
		for (int b = 0; b < MAX_WORD_LEN; b++) begin
			if (len_in == LEN_W'(b)) begin
				chunk_next[b / 8][(b % 8) * 8 +: 8] = in_data.data_byte;
			end
		end
	end

	always_comb begin
		chunk_eq = (rsp.word == chunk_q[k_q]);
		cnt_use  = (k_q == '0) ? rsp.cnt : cnt_q;
		cnt_sat  = (cnt_use == 32'hffffffff) ? cnt_use : cnt_use + 32'd1;
		rd_len   = (rsp.cnt != 32'd0) ? rsp.len : '0;
		rd_n     = (CHUNK_W + 1)'((LEN_W + 1)'(rd_len) + (LEN_W + 1)'(7) >> 3);
		if (rd_n == '0) begin
			rd_n = (CHUNK_W + 1)'(1);
		end
		if (rd_n > (CHUNK_W + 1)'(CHUNKS)) begin
			rd_n = (CHUNK_W + 1)'(CHUNKS);
		end
	end

	// memory port drive
	always_comb begin
		req = '0;
		req.slot_addr = (state_q == S_CLR) ? clr_q : idx_q;
		req.word_addr = {idx_q, k_q};
		req.word_wdata = chunk_q[k_q];
		req.len_wdata = len_q;
		unique case (state_q)
			S_CLR: begin
				req.cnt_we = 1'b1;
				req.cnt_wdata = 32'd0;
			end
			S_PCMP: begin
				if (!(k_q == '0 && rsp.cnt == 32'd0) && (k_q != '0 || rsp.len == len_q)
					&& chunk_eq && k_q == K_LAST) begin
					req.cnt_we = 1'b1;
					req.cnt_wdata = cnt_sat;
				end
			end
			S_INS: begin
				req.word_we = 1'b1;
				if (k_q == '0) begin
					req.cnt_we = 1'b1;
					req.cnt_wdata = 32'd1;
					req.len_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			in_word_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// the emit state loads the output register itself
			if (out_valid_q && !out_stall && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(TABLE_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (in_data.op == OP_READ) begin
							state_q <= S_RRD;
						end else if (is_word_byte) begin
							in_word_q <= 1'b1;
							if (in_data.end_of_data) begin
								state_q <= S_PRD;
							end
						end else if (in_word_q) begin
							state_q <= S_PRD;
						end
					end
				end
				S_PRD: begin
					// overlong words skip the table
					state_q <= overlong_q ? S_EMIT : S_PCMP;
				end
				S_PCMP: begin
					if (k_q == '0 && rsp.cnt == 32'd0) begin
						state_q <= S_INS;
					end else if ((k_q != '0 || rsp.len == len_q) && chunk_eq) begin
						state_q <= (k_q == K_LAST) ? S_EMIT : S_PRD;
					end else if (probes_q == (SLOT_W + 1)'(TABLE_SLOTS - 1)) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_PRD;
					end
				end
				S_INS: begin
					if (k_q == K_LAST) begin
						state_q <= S_EMIT;
					end
				end
				S_RRD: begin
					state_q <= S_RDAT;
				end
				S_RDAT: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (rd_mode_q) begin
							state_q <= res_q.last ? S_IDLE : S_RRD;
						end else begin
							in_word_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					k_q <= '0;
					probes_q <= '0;
					if (in_data.op == OP_READ) begin
						rd_mode_q <= 1'b1;
						idx_q <= in_data.slot_index[SLOT_W-1:0];
					end else if (is_word_byte) begin
						rd_mode_q <= 1'b0;
						hash_q <= hash_next;
						idx_q <= hash_next[SLOT_W-1:0];
						chunk_q <= chunk_next;
						if (len_in < LEN_W'(MAX_WORD_LEN)) begin
							len_q <= len_in + 1'b1;
							overlong_q <= in_word_q ? overlong_q : 1'b0;
						end else begin
							len_q <= len_in;
							overlong_q <= 1'b1;
						end
					end else begin
						rd_mode_q <= 1'b0;
						idx_q <= hash_q[SLOT_W-1:0];
					end
				end
			end
			S_PRD: begin
				if (overlong_q) begin
					res_q <= '{slot: '0, count: '0, wlen: LEN_W'(MAX_WORD_LEN),
						word_hash: hash_q, is_new: 1'b0, status: ST_LONG,
						word_chunk: '0, last: 1'b1};
				end
			end
			S_PCMP: begin
				if (k_q == '0 && rsp.cnt == 32'd0) begin
					k_q <= '0;
				end else if ((k_q != '0 || rsp.len == len_q) && chunk_eq) begin
					if (k_q == '0) begin
						cnt_q <= rsp.cnt;
					end
					if (k_q == K_LAST) begin
						res_q <= '{slot: idx_q, count: cnt_sat, wlen: len_q,
							word_hash: hash_q, is_new: 1'b0, status: ST_OK,
							word_chunk: '0, last: 1'b1};
					end else begin
						k_q <= k_q + 1'b1;
					end
				end else begin
					res_q <= '{slot: '0, count: '0, wlen: len_q,
						word_hash: hash_q, is_new: 1'b0, status: ST_FULL,
						word_chunk: '0, last: 1'b1};
					idx_q <= idx_q + 1'b1;
					probes_q <= probes_q + 1'b1;
					k_q <= '0;
				end
			end
			S_INS: begin
				k_q <= k_q + 1'b1;
				res_q <= '{slot: idx_q, count: 32'd1, wlen: len_q,
					word_hash: hash_q, is_new: 1'b1, status: ST_OK,
					word_chunk: '0, last: 1'b1};
			end
			S_RDAT: begin
				if (k_q == '0) begin
					cnt_q <= rsp.cnt;
					n_q <= rd_n;
					res_q <= '{slot: idx_q, count: rsp.cnt, wlen: rd_len,
						word_hash: '0, is_new: 1'b0, status: ST_OK,
						word_chunk: (rsp.cnt != 32'd0) ? rsp.word : 64'd0,
						last: (rd_n == (CHUNK_W + 1)'(1))};
				end else begin
					res_q <= '{slot: '0, count: '0, wlen: '0,
						word_hash: '0, is_new: 1'b0, status: ST_OK,
						word_chunk: (cnt_q != 32'd0) ? rsp.word : 64'd0,
						last: ((CHUNK_W + 1)'(k_q) + 1'b1 == n_q)};
				end
			end
			S_EMIT: begin
				if (out_free) begin
					out_q <= res_q;
					k_q <= k_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// a fresh insert always reports count one
	a_new_is_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_new |-> out_data.count == 32'd1)
		else $error("new entry with count other than one");

	// dropped words never report a slot or count
	a_drop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.count == 32'd0
		&& out_data.slot == '0)
		else $error("dropped word carries slot or count");

	// probing never runs past one lap of the table
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PCMP |-> probes_q < (SLOT_W + 1)'(TABLE_SLOTS))
		else $error("probe count beyond table size");

	// a result is only loaded when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("pending result overwritten");
endmodule
`default_nettype wire

// File: dv/word_count_hash_table_core_tb.sv
// testbench for the word count hash table core: self-checking against an internal predictor
`timescale 1ns / 100ps
`default_nettype none
module word_count_hash_table_core_tb;
	import wch_pkg::*;

	localparam logic [63:0] FNV_MUL = 64'h00000100000001B3;
	localparam int unsigned NCHUNK = 4;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t  in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;

	word_count_hash_table_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// predictor state, a shadow of the table
	logic [63:0] hash_acc;
	logic        word_open;
	int unsigned word_bytes;
	logic        word_overrun;
	logic [7:0]  letters [MAX_WORD_LEN];
	logic [31:0] tally [TABLE_SLOTS];
	logic [5:0]  tally_len [TABLE_SLOTS];
	logic [63:0] tally_text [TABLE_SLOTS][NCHUNK];

	in_t  pending_reqs [$];
	out_t expected_results [$];
	int   mismatches;
	logic stimulus_done;
	logic hold_off;
	logic quiet;

	initial begin
		clk = 1'b0;
	end
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic is_alnum(input logic [7:0] b);
		return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
	endfunction

	function automatic out_t blank_result();
		out_t r;
		r = '0;
		return r;
	endfunction

	// finish the open word: probe, count, insert or flag
	task automatic finish_word();
		out_t        r;
		logic [63:0] packed_text [NCHUNK];
		int unsigned pos;
		logic        same;
		logic        done;
		r = blank_result();
		r.word_hash = hash_acc;
		r.last = 1'b1;
		done = 1'b0;
		if (word_overrun) begin
			r.status = ST_LONG;
			r.wlen = 6'(MAX_WORD_LEN);
		end else begin
			for (int k = 0; k < NCHUNK; k++)
				packed_text[k] = '0;
			for (int i = 0; i < word_bytes; i++)
				packed_text[i / 8][8 * (i % 8) +: 8] = letters[i];
			r.wlen = 6'(word_bytes);
			pos = hash_acc % TABLE_SLOTS;
			for (int p = 0; p < TABLE_SLOTS && !done; p++) begin
				if (tally[pos] == 0) begin
					tally[pos] = 1;
					tally_len[pos] = 6'(word_bytes);
					for (int k = 0; k < NCHUNK; k++)
						tally_text[pos][k] = packed_text[k];
					r.slot = 10'(pos);
					r.count = 1;
					r.is_new = 1'b1;
					done = 1'b1;
				end else begin
					same = (tally_len[pos] == 6'(word_bytes));
					for (int k = 0; k < NCHUNK; k++)
						if (tally_text[pos][k] != packed_text[k])
							same = 1'b0;
					if (same) begin
						if (tally[pos] != 32'hFFFFFFFF)
							tally[pos]++;
						r.slot = 10'(pos);
						r.count = tally[pos];
						done = 1'b1;
					end
				end
				pos = (pos + 1) % TABLE_SLOTS;
			end
			if (!done)
				r.status = ST_FULL;
		end
		expected_results.push_back(r);
		hash_acc = FNV_BASIS;
		word_open = 1'b0;
		word_bytes = 0;
		word_overrun = 1'b0;
	endtask

	// expected results of one accepted request
	task automatic predict_request(input in_t req);
		out_t        r;
		int unsigned idx;
		int unsigned n;
		logic [5:0]  len;
		if (req.op == OP_READ) begin
			idx = req.slot_index % TABLE_SLOTS;
			len = (tally[idx] != 0) ? tally_len[idx] : 6'd0;
			n = (len + 7) / 8;
			if (n == 0)
				n = 1;
			for (int k = 0; k < n; k++) begin
				r = blank_result();
				if (k == 0) begin
					r.slot = 10'(idx);
					r.count = tally[idx];
					r.wlen = len;
				end
				r.word_chunk = (tally[idx] != 0) ? tally_text[idx][k] : 64'd0;
				r.last = (k + 1 == n);
				expected_results.push_back(r);
			end
		end else if (is_alnum(req.data_byte)) begin
			word_open = 1'b1;
			hash_acc = (hash_acc ^ {56'd0, req.data_byte}) * FNV_MUL;
			if (word_bytes < MAX_WORD_LEN) begin
				letters[word_bytes] = req.data_byte;
				word_bytes++;
			end else begin
				word_overrun = 1'b1;
			end
			if (req.end_of_data)
				finish_word();
		end else if (word_open) begin
			finish_word();
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid)
				predict_request(in_data);
			if (pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= 20)) begin
				in_valid <= 1'b1;
				in_data <= pending_reqs.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result stall, with random idling and a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b1;
		else
			out_stall <= hold_off || (!quiet && $urandom_range(99) < 20);
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", out_data);
			end else if (out_data !== expected_results[0]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p got %p", expected_results[0], out_data);
				void'(expected_results.pop_front());
			end else begin
				void'(expected_results.pop_front());
			end
		end
	end

	task automatic push_feed(input logic [7:0] b, input logic eod);
		in_t q;
		q = '0;
		q.op = OP_FEED;
		q.data_byte = b;
		q.end_of_data = eod;
		q.slot_index = 10'($urandom);
		pending_reqs.push_back(q);
	endtask

	task automatic push_read(input logic [9:0] s);
		in_t q;
		q = '0;
		q.op = OP_READ;
		q.slot_index = s;
		q.data_byte = 8'($urandom);
		q.end_of_data = 1'($urandom);
		pending_reqs.push_back(q);
	endtask

	function automatic logic [7:0] rand_alnum();
		int unsigned k;
		k = $urandom_range(61);
		if (k < 10)
			return 8'("0" + k);
		if (k < 36)
			return 8'("A" + k - 10);
		return 8'("a" + k - 36);
	endfunction

	function automatic logic [7:0] rand_sep();
		logic [7:0] b;
		do
			b = 8'($urandom);
		while (is_alnum(b));
		return b;
	endfunction

	task automatic push_word(input int unsigned n, input logic eod_end);
		for (int i = 0; i < n; i++)
			push_feed(rand_alnum(), eod_end && i == n - 1);
	endtask

	initial begin
		int unsigned dict_len [8];
		logic [7:0]  dict [8][40];
		int unsigned w;
		hash_acc = FNV_BASIS;
		word_open = 1'b0;
		word_bytes = 0;
		word_overrun = 1'b0;
		for (int i = 0; i < TABLE_SLOTS; i++)
			tally[i] = 0;
		mismatches = 0;
		stimulus_done = 1'b0;
		hold_off = 1'b0;
		quiet = 1'b0;
		arst_n = 1'b0;

		// directed: empty read, short words, repeat, overlong, eod closes, sep+eod
		push_read(10'h3FF);
		push_feed("a", 1'b0);
		push_feed(" ", 1'b0);
		push_feed("a", 1'b0);
		push_feed(8'hFF, 1'b1);
		push_feed("Z", 1'b0);
		push_feed("9", 1'b0);
		push_read(10'h000);
		push_feed("0", 1'b1);
		push_feed(8'h00, 1'b1);
		push_word(MAX_WORD_LEN, 1'b0);
		push_feed(8'h80, 1'b0);
		push_word(MAX_WORD_LEN + 3, 1'b1);
		push_word(17, 1'b1);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// a small dictionary so that repeats hit existing slots
		for (int d = 0; d < 8; d++) begin
			dict_len[d] = (d == 7) ? 36 : $urandom_range(1, (d < 4) ? 6 : MAX_WORD_LEN);
			for (int i = 0; i < 40; i++)
				dict[d][i] = rand_alnum();
		end
		w = 0;
		while (w < 380) begin
			case ($urandom_range(9))
				0: begin
					push_read(10'($urandom));
					w++;
				end
				1: begin
					push_feed(8'($urandom), 1'($urandom));
					w++;
				end
				2, 3: begin
					int unsigned n;
					n = $urandom_range(1, 10);
					push_word(n, $urandom_range(3) == 0);
					push_feed(rand_sep(), $urandom_range(5) == 0);
					w += n + 1;
				end
				default: begin
					int unsigned d;
					d = $urandom_range(7);
					for (int i = 0; i < dict_len[d]; i++)
						push_feed(dict[d][i], 1'b0);
					push_feed(rand_sep(), 1'b0);
					w += dict_len[d] + 1;
				end
			endcase
		end
		// finish by reading back eight random slots
		for (int i = 0; i < 8; i++)
			push_read(10'($urandom));

		// long hold-off on the result side while requests keep coming
		wait (pending_reqs.size() < 300);
		quiet = 1'b1;
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
		wait (pending_reqs.size() < 150);
		quiet = 1'b0;

		wait (pending_reqs.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
